FILE: rtl/core/epb_pkg.sv
// ----------------------------------------------------------------------------
// epb_pkg
// types and constants shared by the expiring packet buffer
// ----------------------------------------------------------------------------
package epb_pkg;

  localparam logic [2:0] KIND_ENQ  = 3'd0;
  localparam logic [2:0] KIND_RMV  = 3'd1;
  localparam logic [2:0] KIND_DEQ  = 3'd2;
  localparam logic [2:0] KIND_FIND = 3'd3;
  localparam logic [2:0] KIND_SIZE = 3'd4;
  localparam logic [2:0] KIND_TICK = 3'd5;

  localparam logic CFG_MAX_ENTRIES = 1'b0;
  localparam logic CFG_TIMEOUT     = 1'b1;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] packet_id;
    logic [31:0] source;
    logic [31:0] next_hop;
    logic [31:0] destination;
    logic [15:0] ident;
    logic [15:0] frag_offset;
    logic [7:0]  segs_left;
  } req_t;

  typedef struct packed {
    logic [31:0] packet_id;
    logic [31:0] source;
    logic [31:0] next_hop;
    logic [31:0] destination;
    logic [15:0] ident;
    logic [15:0] frag_offset;
    logic [7:0]  segs_left;
  } desc_t;

  typedef struct packed {
    logic        ok;
    logic        evicted_oldest;
    logic [6:0]  purged_count;
    logic [6:0]  occupancy;
    logic [31:0] out_packet_id;
    logic [31:0] out_source;
    logic [31:0] out_next_hop;
    logic [31:0] out_destination;
    logic [15:0] out_ident;
    logic [15:0] out_frag_offset;
    logic [7:0]  out_segs_left;
  } rsp_t;

  function automatic logic is_dup(desc_t s, req_t r);
    return s.packet_id == r.packet_id && s.source == r.source &&
           s.next_hop == r.next_hop && s.destination == r.destination &&
           s.ident == r.ident && s.frag_offset == r.frag_offset &&
           {1'b0, s.segs_left} == ({1'b0, r.segs_left} + 9'd1);
  endfunction

endpackage

FILE: rtl/core/expiring_packet_buffer.sv
// ----------------------------------------------------------------------------
// expiring_packet_buffer
// ordered descriptor buffer with ageing, purge, dedup and eviction
// ----------------------------------------------------------------------------
// flow: purge, search and eviction or removal shift each walk the entries one by
//   one through the memory's single read port; size runs only the purge, and
//   tick walks every entry to age it
// throughput: one transaction at a time; busy stays high until done_o
// reset: buffer empty, max_entries 50, timeout_ticks 1000; no clearing pass
// the receiver cannot stall: each result strobes done_o for one cycle
module expiring_packet_buffer
  import epb_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  req_t        req_i,
  output logic        done_o,
  output rsp_t        rsp_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_PRD, S_PCHK, S_SRD, S_SCHK, S_SHRD, S_SHWR, S_WRITE,
    S_TRD, S_TWR, S_DONE
  } state_e;

  state_e state_q;
  req_t   req_q;
  logic [6:0]  max_q;
  logic [31:0] tmo_q;
  logic [CW-1:0] fill_q, rd_q, wr_q;
  logic [6:0] purged_q;
  logic ok_q, ev_q, srch_dst_q, rem_q;
  desc_t out_q;

  desc_t       mem_d [DEPTH];
  logic [31:0] mem_a [DEPTH];
  desc_t       rd_d;
  logic [31:0] rd_a;
  logic          we;
  logic [AW-1:0] wa, ra;
  desc_t       wd;
  logic [31:0] wage;

  // read address held in rd_q; data valid next cycle
  assign ra = rd_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_d[wa] <= wd;
      mem_a[wa] <= wage;
    end
    rd_d <= mem_d[ra];
    rd_a <= mem_a[ra];
  end

  logic [CW-1:0] lim;
  always_comb lim = fill_q;

  logic full;
  assign full = fill_q != '0 && (32'(max_q) <= 32'(fill_q) ||
                32'(fill_q) >= 32'(DEPTH));

  desc_t req_desc;
  assign req_desc = '{req_q.packet_id, req_q.source, req_q.next_hop, req_q.destination,
                      req_q.ident, req_q.frag_offset, req_q.segs_left};

  logic hit;
  assign hit = srch_dst_q ? (rd_d.destination == req_q.destination) : is_dup(rd_d, req_q);

  always_comb begin
    we = 1'b0; wa = wr_q[AW-1:0]; wd = rd_d; wage = rd_a;
    case (state_q)
      S_PCHK: we = (rd_a <= tmo_q) && (wr_q != rd_q - CW'(1));
      S_SHWR: we = 1'b1;
      S_WRITE: begin
        we = 1'b1; wa = fill_q[AW-1:0]; wd = req_desc; wage = '0;
      end
      S_TWR: begin
        we = 1'b1; wage = (rd_a == '1) ? rd_a : rd_a + 32'd1;
      end
      default: ;
    endcase
  end

  assign busy = state_q != S_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; fill_q <= '0; max_q <= 7'd50; tmo_q <= 32'd1000;
      done_o <= 1'b0; rd_q <= '0; wr_q <= '0; purged_q <= '0;
      ok_q <= 1'b0; ev_q <= 1'b0; srch_dst_q <= 1'b0; rem_q <= 1'b0;
      req_q <= '0; out_q <= '0; rsp_o <= '0;
    end else begin
      done_o <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_MAX_ENTRIES) max_q <= cfg_data_i[6:0];
        else tmo_q <= cfg_data_i;
      end
      case (state_q)
        S_IDLE: if (start) begin
          req_q <= req_i; rd_q <= '0; wr_q <= '0; purged_q <= '0;
          ok_q <= 1'b0; ev_q <= 1'b0; out_q <= '0;
          srch_dst_q <= req_i.kind == KIND_DEQ || req_i.kind == KIND_FIND;
          case (req_i.kind)
            KIND_ENQ, KIND_DEQ, KIND_SIZE: state_q <= S_PRD;
            KIND_RMV, KIND_FIND: state_q <= S_SRD;
            KIND_TICK: state_q <= S_TRD;
            default: state_q <= S_DONE;
          endcase
        end
        // purge: read entry rd_q, compact survivors down to wr_q
        S_PRD: begin
          if (rd_q >= lim) begin
            fill_q <= wr_q; rd_q <= '0;
            state_q <= (req_q.kind == KIND_SIZE) ? S_DONE : S_SRD;
          end else begin
            state_q <= S_PCHK; rd_q <= rd_q + CW'(1);
          end
        end
        S_PCHK: begin
          if (rd_a > tmo_q) purged_q <= purged_q + 7'd1;
          else wr_q <= wr_q + CW'(1);
          state_q <= S_PRD;
        end
        // search for the first hit
        S_SRD: begin
          if (rd_q >= fill_q) begin
            if (req_q.kind == KIND_ENQ) begin
              if (full) begin
                ev_q <= 1'b1; rd_q <= CW'(1); wr_q <= '0;
                rem_q <= 1'b0; state_q <= S_SHRD;
              end else state_q <= S_WRITE;
            end else state_q <= S_DONE;
          end else begin
            rd_q <= rd_q + CW'(1); state_q <= S_SCHK;
          end
        end
        S_SCHK: begin
          if (hit) begin
            case (req_q.kind)
              KIND_ENQ: state_q <= S_DONE;
              KIND_FIND: begin ok_q <= 1'b1; state_q <= S_DONE; end
              KIND_RMV: begin
                ok_q <= 1'b1; wr_q <= rd_q - CW'(1); rem_q <= 1'b1; state_q <= S_SHRD;
              end
              KIND_DEQ: begin
                ok_q <= 1'b1; out_q <= rd_d; wr_q <= rd_q - CW'(1);
                rem_q <= 1'b1; state_q <= S_SHRD;
              end
              default: state_q <= S_DONE;
            endcase
          end else state_q <= S_SRD;
        end
        // shift entries above wr_q down by one
        S_SHRD: begin
          if (rd_q >= fill_q) begin
            fill_q <= fill_q - CW'(1);
            state_q <= rem_q ? S_DONE : S_WRITE;
          end else begin
            rd_q <= rd_q + CW'(1); state_q <= S_SHWR;
          end
        end
        S_SHWR: begin
          wr_q <= wr_q + CW'(1); state_q <= S_SHRD;
        end
        S_WRITE: begin
          fill_q <= fill_q + CW'(1); ok_q <= 1'b1; state_q <= S_DONE;
        end
        S_TRD: begin
          if (rd_q >= fill_q) state_q <= S_DONE;
          else begin
            wr_q <= rd_q; rd_q <= rd_q + CW'(1); state_q <= S_TWR;
          end
        end
        S_TWR: state_q <= S_TRD;
        S_DONE: begin
          done_o <= 1'b1;
          rsp_o <= '{ok_q, ev_q, purged_q, 7'(fill_q), out_q.packet_id, out_q.source,
                     out_q.next_hop, out_q.destination, out_q.ident, out_q.frag_offset,
                     out_q.segs_left};
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, fill_q} <= (CW+1)'(DEPTH)) else $error("fill count beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |=> done_o) else $error("result strobe missing");

endmodule
